// File: hdl/lpbq_pkg.sv
// ----------------------------------------------------------------------------
// lpbq_pkg
// shared constants, control types and the microcode program of the biquad
// ----------------------------------------------------------------------------
package lpbq_pkg;

	// default widths, also the top-level parameter defaults
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COEF_WIDTH_DEF   = 24;

	// delay elements are signed Q24.16
	localparam int DLY_W    = 40;
	localparam int DLY_FRAC = 16;
	// delay words are split in two halves for the shared multiplier
	localparam int SPLIT    = 20;
	localparam int PIECE_W  = SPLIT + 1;

	// configuration register indexes
	localparam int REG_IDX_W = 3;
	localparam int NUM_COEF  = 5;
	localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

	// program counter
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
	localparam logic [PC_W-1:0] PC_APPLY = 4'd1;
	localparam logic [PC_W-1:0] PC_PRE   = 4'd15;

	typedef enum logic [2:0] {
		CS_B0 = 3'd0,
		CS_B1 = 3'd1,
		CS_B2 = 3'd2,
		CS_A1 = 3'd3,
		CS_A2 = 3'd4
	} coef_sel_t;

	typedef enum logic [1:0] {
		DS_D1 = 2'd0,
		DS_D2 = 2'd1,
		DS_W  = 2'd2
	} dly_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD   = 2'd0,
		ACC_INIT_W = 2'd1,
		ACC_INIT_Y = 2'd2,
		ACC_ADD    = 2'd3
	} acc_op_t;

	// how a step leaves: fall through, or wait on a condition and branch
	typedef enum logic [1:0] {
		J_NEXT   = 2'd0,
		J_INPUT  = 2'd1,
		J_DIV    = 2'd2,
		J_OUTPUT = 2'd3
	} jump_t;

	typedef struct packed {
		coef_sel_t       coef_sel;
		dly_sel_t        dly_sel;
		logic            mul_hi;
		acc_op_t         acc_op;
		logic            w_make;
		jump_t           jump;
		logic [PC_W-1:0] target;
	} ucode_t;

	// sequencer to datapath
	typedef struct packed {
		coef_sel_t coef_sel;
		dly_sel_t  dly_sel;
		logic      mul_hi;
		acc_op_t   acc_op;
		logic      w_make;
		logic      in_ready;
		logic      in_fire;
		logic      div_go;
		logic      pre_load;
		logic      emit;
	} ctl_t;

	// status into the sequencer
	typedef struct packed {
		logic in_valid;
		logic in_op;
		logic div_done;
		logic out_free;
	} stat_t;

	function automatic ucode_t uc_word(
		input coef_sel_t       c,
		input dly_sel_t        d,
		input logic            hi,
		input acc_op_t         a,
		input logic            wm,
		input jump_t           j,
		input logic [PC_W-1:0] t
	);
		ucode_t u;
		u.coef_sel = c;
		u.dly_sel  = d;
		u.mul_hi   = hi;
		u.acc_op   = a;
		u.w_make   = wm;
		u.jump     = j;
		u.target   = t;
		return u;
	endfunction

	// the program: each multiply lands in the accumulator on the step after it
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t u;
		case (pc)
			// wait for a beat, preload branches to the divider wait
			4'd0:  u = uc_word(CS_A1, DS_D1, 1'b0, ACC_HOLD,   1'b0, J_INPUT,  PC_PRE);
			// w = x - a1*d1 - a2*d2
			4'd1:  u = uc_word(CS_A1, DS_D1, 1'b0, ACC_INIT_W, 1'b0, J_NEXT,   PC_WAIT);
			4'd2:  u = uc_word(CS_A1, DS_D1, 1'b1, ACC_ADD,    1'b0, J_NEXT,   PC_WAIT);
			4'd3:  u = uc_word(CS_A2, DS_D2, 1'b0, ACC_ADD,    1'b0, J_NEXT,   PC_WAIT);
			4'd4:  u = uc_word(CS_A2, DS_D2, 1'b1, ACC_ADD,    1'b0, J_NEXT,   PC_WAIT);
			4'd5:  u = uc_word(CS_A2, DS_D2, 1'b1, ACC_ADD,    1'b0, J_NEXT,   PC_WAIT);
			4'd6:  u = uc_word(CS_B0, DS_W,  1'b0, ACC_HOLD,   1'b1, J_NEXT,   PC_WAIT);
			// y = b0*w + b1*d1 + b2*d2
			4'd7:  u = uc_word(CS_B0, DS_W,  1'b0, ACC_INIT_Y, 1'b0, J_NEXT,   PC_WAIT);
			4'd8:  u = uc_word(CS_B0, DS_W,  1'b1, ACC_ADD,    1'b0, J_NEXT,   PC_WAIT);
			4'd9:  u = uc_word(CS_B1, DS_D1, 1'b0, ACC_ADD,    1'b0, J_NEXT,   PC_WAIT);
			4'd10: u = uc_word(CS_B1, DS_D1, 1'b1, ACC_ADD,    1'b0, J_NEXT,   PC_WAIT);
			4'd11: u = uc_word(CS_B2, DS_D2, 1'b0, ACC_ADD,    1'b0, J_NEXT,   PC_WAIT);
			4'd12: u = uc_word(CS_B2, DS_D2, 1'b1, ACC_ADD,    1'b0, J_NEXT,   PC_WAIT);
			4'd13: u = uc_word(CS_B2, DS_D2, 1'b1, ACC_ADD,    1'b0, J_NEXT,   PC_WAIT);
			// hand the result over and shift the delays
			4'd14: u = uc_word(CS_B0, DS_D1, 1'b0, ACC_HOLD,   1'b0, J_OUTPUT, PC_WAIT);
			// wait for the preload quotient, then apply
			4'd15: u = uc_word(CS_B0, DS_D1, 1'b0, ACC_HOLD,   1'b0, J_DIV,    PC_APPLY);
			default: u = uc_word(CS_A1, DS_D1, 1'b0, ACC_HOLD, 1'b0, J_INPUT,  PC_PRE);
		endcase
		return u;
	endfunction

endpackage

// File: hdl/lowpass_biquad_df2.sv
// ----------------------------------------------------------------------------
// lowpass_biquad_df2
// second-order iir biquad, direct form ii, microcoded over one multiplier
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with op and sample; op 0 filters the
//   sample, op 1 first loads both delays with x / (b0 + b1 + b2) and filters
//   output channel: out_valid / out_stall with filtered, guard_hit and
//   out_saturated; exactly one result beat per input beat, in order
//   config: cfg_we, cfg_index, cfg_data write b0, b1, b2, a1, a2 (in that
//   index order) while the block is idle; other indexes are ignored
//   timing: one beat is worked at a time, a 16-step program on a single
//   shared 24 x 21 multiplier; the next beat is taken only at the wait
//   step, after the output step has registered the previous result
//   a preload beat adds the one-bit-per-cycle divider run
//   reset: coefficients return to b0 = 1.0 and the rest zero, delays clear,
//   no result is pending and the sequencer waits for a beat
//   stall: a finished result sits in the output register; while it is held
//   the next beat is still worked and its program parks on its last step,
//   and in_stall stays high until the result is taken and the sequencer is
//   back at its wait step
// ----------------------------------------------------------------------------
module lowpass_biquad_df2 import lpbq_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration writes
	input  logic                           cfg_we,
	input  logic        [REG_IDX_W-1:0]    cfg_index,
	input  logic        [COEF_WIDTH-1:0]   cfg_data,
	// input beats
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	// result beats
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] filtered,
	output logic                           guard_hit,
	output logic                           out_saturated
);

	localparam int COEF_FRAC = COEF_WIDTH - 4;

	// coefficient registers, signed q4.frac
	logic signed [COEF_WIDTH-1:0]   coef_q [NUM_COEF];

	ctl_t                           ctl;
	stat_t                          st;

	logic                           div_done;
	logic                           pre_bad;
	logic        [DLY_W-1:0]        pre_val;

	logic signed [SAMPLE_WIDTH-1:0] y;
	logic                           y_sat;
	logic                           guard;

	// output register, parts the program from the receiver
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] filtered_q;
	logic                           guard_hit_q;
	logic                           out_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
			coef_q[REG_B0] <= COEF_WIDTH'(1) << COEF_FRAC;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_B0:  coef_q[REG_B0] <= cfg_data;
				REG_B1:  coef_q[REG_B1] <= cfg_data;
				REG_B2:  coef_q[REG_B2] <= cfg_data;
				REG_A1:  coef_q[REG_A1] <= cfg_data;
				REG_A2:  coef_q[REG_A2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// status the program branches on
	assign st.in_valid = in_valid;
	assign st.in_op    = op;
	assign st.div_done = div_done;
	assign st.out_free = !out_valid_q || !out_stall;

	lpbq_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctl    (ctl)
	);

	// preload divider starts on the accept edge of an op 1 beat
	lpbq_div #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.div_go),
		.sample  (sample),
		.b0      (coef_q[REG_B0]),
		.b1      (coef_q[REG_B1]),
		.b2      (coef_q[REG_B2]),
		.done    (div_done),
		.pre_bad (pre_bad),
		.pre_val (pre_val)
	);

	lpbq_mac #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.sample  (sample),
		.coef    (coef_q),
		.pre_bad (pre_bad),
		.pre_val (pre_val),
		.y       (y),
		.y_sat   (y_sat),
		.guard   (guard)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			filtered_q  <= y;
			guard_hit_q <= guard;
			out_sat_q   <= y_sat;
		end
	end

	assign in_stall      = !ctl.in_ready;
	assign out_valid     = out_valid_q;
	assign filtered      = filtered_q;
	assign guard_hit     = guard_hit_q;
	assign out_saturated = out_sat_q;

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid_q || !out_stall))
		else $error("result beat overwritten while stalled");

	// one beat in flight: the cycle after an accept takes nothing
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second beat taken while the first is in work");

	// every emitted result shows on the port in the next cycle
	a_emit_visible: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> out_valid)
		else $error("emitted result missing on the output");

endmodule

// File: hdl/lpbq_seq.sv
// ----------------------------------------------------------------------------
// lpbq_seq
// step counter and microcode table, drives the datapath one word a cycle
// ----------------------------------------------------------------------------
module lpbq_seq import lpbq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t st,
	output ctl_t  ctl
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	ucode_t          uc;

	assign uc = ucode_rom(pc_q);

	always_comb begin
		pc_d         = pc_q;
		ctl.coef_sel = uc.coef_sel;
		ctl.dly_sel  = uc.dly_sel;
		ctl.mul_hi   = uc.mul_hi;
		ctl.acc_op   = uc.acc_op;
		ctl.w_make   = uc.w_make;
		ctl.in_ready = 1'b0;
		ctl.in_fire  = 1'b0;
		ctl.div_go   = 1'b0;
		ctl.pre_load = 1'b0;
		ctl.emit     = 1'b0;
		case (uc.jump)
			J_NEXT: begin
				pc_d = pc_q + PC_W'(1);
			end
			J_INPUT: begin
				ctl.in_ready = 1'b1;
				if (st.in_valid) begin
					ctl.in_fire = 1'b1;
					ctl.div_go  = st.in_op;
					pc_d        = st.in_op ? uc.target : pc_q + PC_W'(1);
				end
			end
			J_DIV: begin
				if (st.div_done) begin
					ctl.pre_load = 1'b1;
					pc_d         = uc.target;
				end
			end
			J_OUTPUT: begin
				if (st.out_free) begin
					ctl.emit = 1'b1;
					pc_d     = uc.target;
				end
			end
			default: begin
				pc_d = PC_WAIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

	// a plain apply beat starts the program at its first multiply
	a_apply_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.in_fire && !st.in_op) |=> (pc_q == PC_APPLY))
		else $error("apply beat did not enter the filter program");

	// a preload beat always parks on the divider wait
	a_pre_entry: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_go |=> (pc_q == PC_PRE))
		else $error("preload beat did not wait for the divider");

endmodule

// File: hdl/lpbq_div.sv
// ----------------------------------------------------------------------------
// lpbq_div
// restoring divider for the preload level x / (b0 + b1 + b2), one bit a cycle
// ----------------------------------------------------------------------------
module lpbq_div import lpbq_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [COEF_WIDTH-1:0]   b0,
	input  logic signed [COEF_WIDTH-1:0]   b1,
	input  logic signed [COEF_WIDTH-1:0]   b2,
	output logic                           done,
	output logic                           pre_bad,
	output logic        [DLY_W-1:0]        pre_val
);

	localparam int FRAC   = COEF_WIDTH - 4 + DLY_FRAC;
	localparam int DIVD_W = SAMPLE_WIDTH + FRAC;
	localparam int SUM_W  = COEF_WIDTH + 2;
	localparam int CNT_W  = $clog2(DIVD_W + 1);
	localparam int QX_W   = (DIVD_W > DLY_W + 1) ? DIVD_W : DLY_W + 1;

	logic signed [SUM_W-1:0]        sum;
	logic        [SUM_W-1:0]        sum_mag;
	logic        [SAMPLE_WIDTH-1:0] x_mag;
	logic        [SUM_W-1:0]        trial;
	logic                           take;
	logic        [QX_W-1:0]         qx;
	logic                           ovf;

	logic                           busy_q;
	logic                           done_q;
	logic        [CNT_W-1:0]        cnt_q;
	logic        [SUM_W-1:0]        rem_q;
	logic        [DIVD_W-1:0]       quo_q;
	logic        [SUM_W-1:0]        dvs_q;
	logic                           neg_q;
	logic                           zero_q;

	assign sum     = SUM_W'(b0) + SUM_W'(b1) + SUM_W'(b2);
	assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
	assign x_mag   = sample[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-sample) : SAMPLE_WIDTH'(sample);

	assign trial = {rem_q[SUM_W-2:0], quo_q[DIVD_W-1]};
	assign take  = (trial >= dvs_q);

	// negative side may reach exactly -2^39
	assign qx  = QX_W'(quo_q);
	assign ovf = (|qx[QX_W-1:DLY_W]) ||
		(qx[DLY_W-1] && (!neg_q || (|qx[DLY_W-2:0])));

	assign pre_val = neg_q ? DLY_W'(-qx[DLY_W-1:0]) : qx[DLY_W-1:0];
	assign pre_bad = zero_q || ovf;
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= {x_mag, {FRAC{1'b0}}};
			dvs_q  <= sum_mag;
			neg_q  <= sample[SAMPLE_WIDTH-1] ^ sum[SUM_W-1];
			zero_q <= (sum == '0);
		end else if (busy_q) begin
			rem_q <= take ? (trial - dvs_q) : trial;
			quo_q <= {quo_q[DIVD_W-2:0], take};
		end
	end

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && !done_q))
		else $error("divider did not start");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(busy_q) && !busy_q))
		else $error("divider done without a finished run");

endmodule

// File: hdl/lpbq_mac.sv
// ----------------------------------------------------------------------------
// lpbq_mac
// datapath: shared multiplier, accumulator, delay line, guard and clip
// ----------------------------------------------------------------------------
module lpbq_mac import lpbq_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ctl_t                           ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [COEF_WIDTH-1:0]   coef [NUM_COEF],
	input  logic                           pre_bad,
	input  logic        [DLY_W-1:0]        pre_val,
	output logic signed [SAMPLE_WIDTH-1:0] y,
	output logic                           y_sat,
	output logic                           guard
);

	localparam int COEF_FRAC = COEF_WIDTH - 4;
	localparam int PROD_W    = COEF_WIDTH + PIECE_W;
	localparam int ACC_W     = COEF_WIDTH + DLY_W + 3;
	localparam int WSW       = ACC_W - COEF_FRAC;
	localparam int DFW       = WSW + 1;
	localparam int YSHIFT    = COEF_FRAC + DLY_FRAC;
	localparam int YW        = ACC_W - YSHIFT;
	localparam logic signed [ACC_W-1:0] W_RND = ACC_W'(1) <<< (COEF_FRAC - 1);
	localparam logic signed [ACC_W-1:0] Y_RND = ACC_W'(1) <<< (YSHIFT - 1);

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [DLY_W-1:0]        d1_q;
	logic signed [DLY_W-1:0]        d2_q;
	logic signed [DLY_W-1:0]        w_q;
	logic                           guard_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic                           hi_q;
	logic signed [ACC_W-1:0]        acc_q;

	logic signed [COEF_WIDTH-1:0]   coef_m;
	logic signed [DLY_W-1:0]        dly_m;
	logic signed [PIECE_W-1:0]      piece;
	logic signed [PROD_W-1:0]       prod_d;
	logic signed [ACC_W-1:0]        addend;
	logic signed [ACC_W-1:0]        acc_d;
	logic signed [DLY_W-1:0]        xq;
	logic signed [WSW-1:0]          wsh;
	logic signed [DFW-1:0]          diff;
	logic                           w_fits;
	logic signed [YW-1:0]           ysh;
	logic                           y_fits;

	always_comb begin
		case (ctl.coef_sel)
			CS_B0:   coef_m = coef[REG_B0];
			CS_B1:   coef_m = coef[REG_B1];
			CS_B2:   coef_m = coef[REG_B2];
			CS_A1:   coef_m = coef[REG_A1];
			CS_A2:   coef_m = coef[REG_A2];
			default: coef_m = coef[REG_B0];
		endcase
		case (ctl.dly_sel)
			DS_D1:   dly_m = d1_q;
			DS_D2:   dly_m = d2_q;
			DS_W:    dly_m = w_q;
			default: dly_m = d1_q;
		endcase
	end

	// upper half signed, lower half as a positive 21-bit value
	assign piece  = ctl.mul_hi ? {dly_m[DLY_W-1], dly_m[DLY_W-1:SPLIT]} :
		{1'b0, dly_m[SPLIT-1:0]};
	assign prod_d = PROD_W'(coef_m) * PROD_W'(piece);

	assign addend = hi_q ? (ACC_W'(prod_q) <<< SPLIT) : ACC_W'(prod_q);

	always_comb begin
		case (ctl.acc_op)
			ACC_HOLD:   acc_d = acc_q;
			ACC_INIT_W: acc_d = W_RND;
			ACC_INIT_Y: acc_d = Y_RND;
			ACC_ADD:    acc_d = acc_q + addend;
			default:    acc_d = acc_q;
		endcase
	end

	// w guard against the 40-bit delay range
	assign xq     = DLY_W'(x_q) <<< DLY_FRAC;
	assign wsh    = WSW'(acc_q >>> COEF_FRAC);
	assign diff   = DFW'(xq) - DFW'(wsh);
	assign w_fits = (&diff[DFW-1:DLY_W-1]) || !(|diff[DFW-1:DLY_W-1]);

	// output clip
	assign ysh    = YW'(acc_q >>> YSHIFT);
	assign y_fits = (&ysh[YW-1:SAMPLE_WIDTH-1]) || !(|ysh[YW-1:SAMPLE_WIDTH-1]);
	assign y      = y_fits ? ysh[SAMPLE_WIDTH-1:0] :
		(ysh[YW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
	assign y_sat  = !y_fits;
	assign guard  = guard_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (ctl.pre_load) begin
			d1_q <= pre_bad ? xq : DLY_W'(signed'(pre_val));
			d2_q <= pre_bad ? xq : DLY_W'(signed'(pre_val));
		end else if (ctl.emit) begin
			d1_q <= w_q;
			d2_q <= d1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.in_fire) begin
			x_q <= sample;
		end
		if (ctl.w_make) begin
			w_q     <= w_fits ? diff[DLY_W-1:0] : xq;
			guard_q <= !w_fits;
		end
		prod_q <= prod_d;
		hi_q   <= ctl.mul_hi;
		acc_q  <= acc_d;
	end

endmodule

// File: bench/biquad_monitor.sv
// ----------------------------------------------------------------------------
// biquad_monitor
// follows the config port and both beat channels, keeps a bit-true copy of
// the filter and compares each result beat with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module biquad_monitor import lpbq_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic        [REG_IDX_W-1:0]    cfg_index,
	input  logic        [COEF_WIDTH-1:0]   cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           op,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] filtered,
	input  logic                           guard_hit,
	input  logic                           out_saturated,
	output int                             fail_count,
	output int                             outstanding
);

	localparam int COEF_FRAC = COEF_WIDTH - 4;
	// wide enough for every exact product sum
	localparam int WIDE = 96;
	localparam logic signed [WIDE-1:0] ONE_W   = 1;
	localparam logic signed [WIDE-1:0] DLY_MAX = (ONE_W <<< (DLY_W - 1)) - ONE_W;
	localparam logic signed [WIDE-1:0] DLY_MIN = -(ONE_W <<< (DLY_W - 1));
	localparam logic signed [WIDE-1:0] OUT_MAX = (ONE_W <<< (SAMPLE_WIDTH - 1)) - ONE_W;
	localparam logic signed [WIDE-1:0] OUT_MIN = -(ONE_W <<< (SAMPLE_WIDTH - 1));
	localparam logic signed [WIDE-1:0] HALF_W  = ONE_W <<< (COEF_FRAC - 1);
	localparam logic signed [WIDE-1:0] HALF_Y  = ONE_W <<< (COEF_FRAC + DLY_FRAC - 1);

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] filtered;
		logic                           guard_hit;
		logic                           out_saturated;
	} biquad_out_t;

	logic signed [COEF_WIDTH-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
	logic signed [DLY_W-1:0]      dly1, dly2;
	biquad_out_t                  predicted_out[$];
	int                           n_fail = 0;

	// one filter step; updates the delay copy
	function automatic biquad_out_t biquad_predict(
		input logic                           preload,
		input logic signed [SAMPLE_WIDTH-1:0] x
	);
		logic signed [WIDE-1:0] xw, xq, gain, pre, acc, w, y;
		logic [63:0]            mag_x, mag_gain, quot;
		logic                   neg, fits;
		biquad_out_t            r;
		xw = WIDE'(x);
		xq = xw <<< DLY_FRAC;
		r.guard_hit     = 1'b0;
		r.out_saturated = 1'b0;
		if (preload) begin
			// steady state x / dc gain, falls back to x on zero gain or overflow
			gain = WIDE'(coef_b0) + WIDE'(coef_b1) + WIDE'(coef_b2);
			pre  = xq;
			if (gain != '0) begin
				mag_x    = xw[WIDE-1] ? 64'(-xw) : 64'(xw);
				mag_gain = gain[WIDE-1] ? 64'(-gain) : 64'(gain);
				quot     = (mag_x << (COEF_FRAC + DLY_FRAC)) / mag_gain;
				neg      = xw[WIDE-1] != gain[WIDE-1];
				fits     = neg ? (quot <= (64'd1 << (DLY_W - 1)))
				               : (quot < (64'd1 << (DLY_W - 1)));
				if (fits) begin
					pre = WIDE'(quot);
					if (neg)
						pre = -pre;
				end
			end
			dly1 = pre[DLY_W-1:0];
			dly2 = pre[DLY_W-1:0];
		end
		acc = WIDE'(coef_a1) * WIDE'(dly1) + WIDE'(coef_a2) * WIDE'(dly2);
		w   = xq - ((acc + HALF_W) >>> COEF_FRAC);
		if (w > DLY_MAX || w < DLY_MIN) begin
			w           = xq;
			r.guard_hit = 1'b1;
		end
		acc = WIDE'(coef_b0) * w + WIDE'(coef_b1) * WIDE'(dly1) +
			WIDE'(coef_b2) * WIDE'(dly2);
		y   = (acc + HALF_Y) >>> (COEF_FRAC + DLY_FRAC);
		if (y > OUT_MAX) begin
			y               = OUT_MAX;
			r.out_saturated = 1'b1;
		end else if (y < OUT_MIN) begin
			y               = OUT_MIN;
			r.out_saturated = 1'b1;
		end
		r.filtered = y[SAMPLE_WIDTH-1:0];
		dly2 = dly1;
		dly1 = w[DLY_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		biquad_out_t want;
		if (!arst_n) begin
			coef_b0 = COEF_WIDTH'(1) <<< COEF_FRAC;
			coef_b1 = '0;
			coef_b2 = '0;
			coef_a1 = '0;
			coef_a2 = '0;
			dly1    = '0;
			dly2    = '0;
			predicted_out.delete();
			outstanding <= 0;
			fail_count  <= n_fail;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_B0:  coef_b0 = cfg_data;
					REG_B1:  coef_b1 = cfg_data;
					REG_B2:  coef_b2 = cfg_data;
					REG_A1:  coef_a1 = cfg_data;
					REG_A2:  coef_a2 = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (predicted_out.size() == 0) begin
					$error("unexpected result beat: filtered %0d", filtered);
					n_fail++;
				end else begin
					want = predicted_out.pop_front();
					if (filtered !== want.filtered) begin
						$error("filtered: expected %0d, got %0d", want.filtered, filtered);
						n_fail++;
					end
					if (guard_hit !== want.guard_hit) begin
						$error("guard_hit: expected %0d, got %0d", want.guard_hit, guard_hit);
						n_fail++;
					end
					if (out_saturated !== want.out_saturated) begin
						$error("out_saturated: expected %0d, got %0d",
							want.out_saturated, out_saturated);
						n_fail++;
					end
				end
			end
			if (in_valid && !in_stall)
				predicted_out.push_back(biquad_predict(op, sample));
			fail_count  <= n_fail;
			outstanding <= predicted_out.size();
		end
	end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives the biquad with directed and random sample beats over several
// coefficient sets, with random gaps and stalls on both channels; the
// monitor beside the block predicts and checks every result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
	import lpbq_pkg::*;

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int CW = COEF_WIDTH_DEF;

	// beat kinds on the op field
	localparam logic OP_APPLY   = 1'b0;
	localparam logic OP_PRELOAD = 1'b1;

	localparam int ITEMS_PER_PHASE = 50;
	localparam int RANDOM_PHASES   = 16;
	// receiver hold-off that backs the block up
	localparam int HOLD_LEN        = 400;
	// no beat moving for this long means a hang
	localparam int QUIET_LIMIT     = 5000;
	// cycles for the sequencer to get back to its wait step
	localparam int SETTLE          = 20;

	localparam int ONE_Q = 1 << (CW - 4);
	localparam logic signed [CW-1:0] C_ONE = CW'(ONE_Q);
	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CW-1:0]        cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 op        = OP_APPLY;
	logic signed [SW-1:0] sample    = '0;
	logic                 out_stall = 1'b0;
	logic                 in_stall;
	logic                 out_valid;
	logic signed [SW-1:0] filtered;
	logic                 guard_hit;
	logic                 out_saturated;
	int                   fail_count;
	int                   outstanding;
	// phase-wide switch for back-to-back input beats
	bit                   sender_calm = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	lowpass_biquad_df2 u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.filtered      (filtered),
		.guard_hit     (guard_hit),
		.out_saturated (out_saturated)
	);

	biquad_monitor u_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.filtered      (filtered),
		.guard_hit     (guard_hit),
		.out_saturated (out_saturated),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	// mostly short idle runs, now and then a long one
	function automatic int gap_len(input bit allow_zero);
		int r;
		r = $urandom_range(0, 99);
		if (allow_zero && r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// sample values weighted toward the corners
	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return S_MAX;
			1:       return S_MIN;
			2:       return SW'($urandom_range(0, 127) - 64);
			3:       return SW'($urandom_range(0, 2) - 1);
			default: return SW'($urandom);
		endcase
	endfunction

	function automatic logic signed [CW-1:0] pick_corner_coef();
		case ($urandom_range(0, 6))
			0:       return C_MAX;
			1:       return C_MIN;
			2:       return '0;
			3:       return C_ONE;
			4:       return -C_ONE;
			5:       return CW'(1);
			default: return CW'(-1);
		endcase
	endfunction

	// one input beat; returns at the edge that takes it, valid still high
	task automatic send_beat(input logic kind, input logic signed [SW-1:0] x);
		int gap;
		gap = sender_calm ? 0 : gap_len(1'b1);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= kind;
		sample   <= x;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// drop valid and wait until every predicted beat has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write enable stays up across back-to-back writes
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic load_coefs(
		input logic signed [CW-1:0] b0,
		input logic signed [CW-1:0] b1,
		input logic signed [CW-1:0] b2,
		input logic signed [CW-1:0] a1,
		input logic signed [CW-1:0] a2
	);
		write_reg(REG_B0, b0);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		write_reg(REG_A1, a1);
		write_reg(REG_A2, a2);
		// an index past the last register must leave everything alone
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_IDX_W'(NUM_COEF + $urandom_range(0, 2)), CW'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase();
		logic signed [CW-1:0] b0, b1, b2, a1, a2;
		int                   mode, k, t0, t1, pre_pct;
		mode    = $urandom_range(0, 9);
		pre_pct = 15;
		case (mode) inside
			[0:3]: begin
				// lowpass-like, stable or close to the edge
				b0 = CW'($urandom_range(0, ONE_Q / 2));
				b1 = CW'($urandom_range(0, ONE_Q));
				b2 = CW'($urandom_range(0, ONE_Q / 2));
				a1 = CW'(-$urandom_range(0, 2 * ONE_Q - 1));
				a2 = CW'($urandom_range(0, ONE_Q - 1));
			end
			[4:5]: begin
				b0 = CW'($urandom);
				b1 = CW'($urandom);
				b2 = CW'($urandom);
				a1 = CW'($urandom);
				a2 = CW'($urandom);
			end
			[6:7]: begin
				b0 = pick_corner_coef();
				b1 = pick_corner_coef();
				b2 = pick_corner_coef();
				a1 = pick_corner_coef();
				a2 = pick_corner_coef();
			end
			8: begin
				// dc gain of zero, preload falls back to the sample
				t0 = $urandom_range(0, 2 * (ONE_Q * 4 - 1)) - (ONE_Q * 4 - 1);
				t1 = $urandom_range(0, 2 * (ONE_Q * 4 - 1)) - (ONE_Q * 4 - 1);
				b0 = CW'(t0);
				b1 = CW'(t1);
				b2 = CW'(-(t0 + t1));
				a1 = CW'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
				a2 = CW'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
				pre_pct = 40;
			end
			default: begin
				// tiny dc gain, preload quotient near or past the delay range
				t0 = $urandom_range(1, 16);
				if ($urandom_range(0, 1) == 1)
					t0 = -t0;
				t1 = $urandom_range(0, 2 * ONE_Q) - ONE_Q;
				b0 = CW'(t0);
				b1 = CW'(t1);
				b2 = CW'(-t1);
				a1 = CW'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
				a2 = CW'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
				pre_pct = 50;
			end
		endcase
		load_coefs(b0, b1, b2, a1, a2);
		sender_calm = ($urandom_range(0, 4) == 0);
		// a run normally starts from a preloaded state
		send_beat(OP_PRELOAD, pick_sample());
		for (k = 1; k < ITEMS_PER_PHASE; k++)
			send_beat(($urandom_range(0, 99) < pre_pct) ? OP_PRELOAD : OP_APPLY, pick_sample());
		settle();
	endtask

	// receiver: alternating ready runs and stalls, one long hold-off
	initial begin : receiver
		int left, taken;
		bit hold, squeezed;
		left     = 0;
		taken    = 0;
		hold     = 1'b0;
		squeezed = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				taken++;
			if (left == 0) begin
				if (!squeezed && taken >= 200) begin
					// sender keeps offering while results back up
					hold     = 1'b1;
					left     = HOLD_LEN;
					squeezed = 1'b1;
				end else if (hold) begin
					hold = 1'b0;
					left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
					                                   : $urandom_range(1, 25);
				end else begin
					hold = 1'b1;
					left = gap_len(1'b0);
				end
			end
			out_stall <= hold;
			left--;
		end
	end

	// hang detector: counts cycles in which no beat moves
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int p;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients: b0 = 1.0, so the filter passes samples through
		send_beat(OP_APPLY, '0);
		send_beat(OP_APPLY, S_MAX);
		send_beat(OP_APPLY, S_MIN);
		send_beat(OP_APPLY, SW'(-1));
		send_beat(OP_PRELOAD, S_MAX);
		send_beat(OP_PRELOAD, S_MIN);
		send_beat(OP_APPLY, SW'(1));
		settle();

		// a real lowpass, preload to steady state then hit the rails
		load_coefs(CW'(70781), CW'(141562), CW'(70781), CW'(-1198510), CW'(432847));
		send_beat(OP_PRELOAD, SW'(1000));
		send_beat(OP_APPLY, SW'(1000));
		send_beat(OP_APPLY, SW'(1000));
		send_beat(OP_APPLY, SW'(1000));
		send_beat(OP_APPLY, S_MIN);
		send_beat(OP_APPLY, S_MIN);
		send_beat(OP_APPLY, S_MAX);
		settle();

		// largest gains: output clipping and runaway feedback
		load_coefs(C_MAX, C_MAX, C_MAX, C_MIN, C_MAX);
		send_beat(OP_APPLY, S_MAX);
		send_beat(OP_APPLY, S_MIN);
		send_beat(OP_PRELOAD, S_MAX);
		send_beat(OP_APPLY, SW'(12345));
		settle();

		// zero dc gain on preload, feedback at the corners trips the guard
		load_coefs(C_ONE, -(C_ONE <<< 1), C_ONE, C_MIN, C_MAX);
		send_beat(OP_PRELOAD, SW'(500));
		send_beat(OP_APPLY, S_MAX);
		send_beat(OP_APPLY, S_MIN);
		send_beat(OP_APPLY, S_MAX);
		settle();

		// dc gain of one lsb: preload quotient right at the delay range limits
		load_coefs(CW'(1), '0, '0, '0, '0);
		send_beat(OP_PRELOAD, SW'(-8));
		send_beat(OP_PRELOAD, SW'(8));
		send_beat(OP_PRELOAD, SW'(7));
		send_beat(OP_PRELOAD, SW'(-9));
		settle();

		for (p = 0; p < RANDOM_PHASES; p++)
			random_phase();

		if (fail_count == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
